[rtl/core/pil_pkg.sv]
// ----------------------------------------------------------------------------
// pil_pkg
// Shared types and constants for the packet interval learner: beat payloads,
// register indexes, reset values, event status codes and divider widths.
// ----------------------------------------------------------------------------
package pil_pkg;

	// configuration register widths
	localparam int NOMINAL_W   = 30;
	localparam int TOL_W       = 17;
	localparam int MULT_W      = 8;
	localparam int TIMEOUT_W   = 32;
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_INDEX_W = 2;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_NOMINAL  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TOL      = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MULT     = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT  = 2'd3;

	// configuration reset values
	localparam logic [NOMINAL_W-1:0] NOMINAL_RST = 30'd300000;
	localparam logic [TOL_W-1:0]     TOL_RST     = 17'd2000;
	localparam logic [MULT_W-1:0]    MULT_RST    = 8'd10;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 32'd3600000;

	// time and gap width
	localparam int TIME_W = 32;

	// shared divider widths: dividend is a gap plus half a period
	localparam int DIV_NUM_W = 33;
	localparam int DIV_DEN_W = 30;

	// led blink slots, counted in units of four milliseconds
	localparam logic [8:0] LED_SLOT0    = 9'd75;
	localparam logic [8:0] LED_SLOT1    = 9'd150;
	localparam logic [8:0] LED_SLOT2    = 9'd225;
	localparam logic [8:0] LED_SLOT3    = 9'd300;
	localparam logic [8:0] LED_FAR_LIM  = 9'd255;

	// event status codes
	localparam logic [2:0] EV_TICK    = 3'd0;
	localparam logic [2:0] EV_OTHER   = 3'd1;
	localparam logic [2:0] EV_REF     = 3'd2;
	localparam logic [2:0] EV_REJECT  = 3'd3;
	localparam logic [2:0] EV_STORED  = 3'd4;
	localparam logic [2:0] EV_FULL    = 3'd5;
	localparam logic [2:0] EV_LEARNED = 3'd6;
	localparam logic [2:0] EV_RESTART = 3'd7;

	// input beat
	typedef struct packed {
		logic              cmd;
		logic [1:0]        channel;
		logic [TIME_W-1:0] now;
	} item_t;

	// result beat
	typedef struct packed {
		logic [TIME_W-1:0] delay;
		logic              too_far;
		logic [2:0]        captured_count;
		logic              led;
		logic [2:0]        event_status;
	} result_t;

endpackage

[rtl/core/pil_div.sv]
// ----------------------------------------------------------------------------
// pil_div
// Restoring unsigned divider, one quotient bit per cycle. Used for both the
// period count and the fold of a long gap by that count.
// ----------------------------------------------------------------------------
module pil_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pil_pkg::DIV_NUM_W-1:0] dividend,
	input  logic [pil_pkg::DIV_DEN_W-1:0] divisor,
	output logic                          done,
	output logic [pil_pkg::DIV_NUM_W-1:0] quotient
);

	localparam int NUM_W = pil_pkg::DIV_NUM_W;
	localparam int DEN_W = pil_pkg::DIV_DEN_W;
	localparam int CNT_W = $clog2(NUM_W);

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             fits;

	// one trial subtraction per cycle
	always_comb begin
		trial = {rem_q, quo_q[NUM_W-1]};
		diff  = trial - {1'b0, den_q};
		fits  = (trial >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				quo_q  <= dividend;
				rem_q  <= '0;
				den_q  <= divisor;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], fits};
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[rtl/core/packet_interval_learner_top.sv]
// A tick, another channel's packet or the first reference goes from S_IDLE
// to S_EMIT; a channel 0 gap passes S_FOLD, the shared one-bit-per-cycle
// divider (S_DIV_CNT, S_DIV_GAP) for a long gap, S_CHECK and, once the store
// fills, S_SCAN and S_SPREAD. Items are handled one at a time; a new item is
// taken once the result is loaded into the output register. Reset clears all
// timing state and the gap count and restores register defaults; gap store
// entries are not cleared.
// ----------------------------------------------------------------------------
// packet_interval_learner_top
// Learns a transmitter's packet period from timestamps, folds long gaps by
// their period multiple, fills a small gap store and checks its spread.
// ----------------------------------------------------------------------------
module packet_interval_learner_top #(
	parameter int GAP_SLOTS = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  pil_pkg::item_t                  item,
	output logic                            result_valid,
	input  logic                            result_stall,
	output pil_pkg::result_t                result,
	input  logic                            cfg_we,
	input  logic [pil_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [pil_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int TW    = pil_pkg::TIME_W;
	localparam int NW    = pil_pkg::NOMINAL_W;
	localparam int CNT_W = $clog2(GAP_SLOTS + 1);
	localparam int IDX_W = (GAP_SLOTS > 1) ? $clog2(GAP_SLOTS) : 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FOLD,
		S_DIV_CNT,
		S_DIV_GAP,
		S_CHECK,
		S_SCAN,
		S_SPREAD,
		S_EMIT
	} state_t;

	state_t state_q;

	// configuration registers
	logic [NW-1:0]                 nominal_q;
	logic [pil_pkg::TOL_W-1:0]     tol_q;
	logic [pil_pkg::MULT_W-1:0]    mult_q;
	logic [pil_pkg::TIMEOUT_W-1:0] timeout_q;

	// learner state
	logic [TW-1:0]    last_any_q;
	logic [TW-1:0]    last_ref_q;
	logic [CNT_W-1:0] count_q;
	logic [TW-1:0]    learned_q;
	logic [TW-1:0]    store_q [GAP_SLOTS];

	// per item working registers
	logic [TW-1:0]    now_q;
	logic [TW-1:0]    gap_q;
	logic [TW-1:0]    fold_q;
	logic [2:0]       status_q;
	logic [IDX_W-1:0] scan_q;
	logic [TW-1:0]    lo_q;
	logic [TW-1:0]    hi_q;

	logic             result_valid_q;
	pil_pkg::result_t result_q;

	// divider hookup
	logic                                  div_start;
	logic [pil_pkg::DIV_NUM_W-1:0]         div_num;
	logic [pil_pkg::DIV_DEN_W-1:0]         div_den;
	logic                                  div_done;
	logic [pil_pkg::DIV_NUM_W-1:0]         div_quo;

	logic [NW-1:0]    nom_eff;
	logic [NW:0]      win_hi;
	logic             needs_fold;
	logic             cnt_over;
	logic             win_reject;
	logic             store_full;
	logic             store_ok;
	logic [TW-1:0]    scan_rd;
	logic [TW-1:0]    spread;

	logic [TW-1:0]    since_any;
	logic             far;
	logic [8:0]       led_slot;
	logic             led_on;
	pil_pkg::result_t result_next;

	// effective period and acceptance window
	always_comb begin
		nom_eff    = (nominal_q == '0) ? NW'(1) : nominal_q;
		win_hi     = {1'b0, nom_eff} + (NW+1)'(tol_q);
		needs_fold = ({1'b0, gap_q} >= (TW+1)'(win_hi));
		cnt_over   = (div_quo > pil_pkg::DIV_NUM_W'(mult_q));
		win_reject = (({2'b0, fold_q} + (TW+2)'(tol_q)) < (TW+2)'(nom_eff)) ||
			({1'b0, fold_q} > (TW+1)'(win_hi));
		store_full = (32'(count_q) >= 32'(GAP_SLOTS));
		store_ok   = !win_reject && !store_full;
		scan_rd    = store_q[scan_q];
		spread     = hi_q - lo_q;
	end

	// divider operands: period count first, then gap by count
	always_comb begin
		div_start = 1'b0;
		div_num   = {1'b0, gap_q};
		div_den   = pil_pkg::DIV_DEN_W'(div_quo[pil_pkg::MULT_W-1:0]);
		if (state_q == S_FOLD) begin
			div_start = needs_fold;
			div_num   = {1'b0, gap_q} + pil_pkg::DIV_NUM_W'(nom_eff >> 1);
			div_den   = nom_eff;
		end else if (state_q == S_DIV_CNT) begin
			div_start = div_done && !cnt_over;
		end
	end

	pil_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_quo)
	);

	// result fields from the settled state
	always_comb begin
		since_any = now_q - last_any_q;
		far       = (since_any > timeout_q);
		led_slot  = now_q[10:2];
		if (far) begin
			led_on = (led_slot < pil_pkg::LED_FAR_LIM);
		end else if (32'(count_q) == 32'(GAP_SLOTS)) begin
			led_on = 1'b0;
		end else begin
			led_on = (led_slot == pil_pkg::LED_SLOT0) ||
				(led_slot == pil_pkg::LED_SLOT1 && 32'(count_q) > 32'd0) ||
				(led_slot == pil_pkg::LED_SLOT2 && 32'(count_q) > 32'd1) ||
				(led_slot == pil_pkg::LED_SLOT3 && 32'(count_q) > 32'd2);
		end
		result_next.delay = (!far && 32'(count_q) == 32'(GAP_SLOTS)) ? learned_q : '0;
		result_next.too_far        = far;
		result_next.captured_count = 3'(count_q);
		result_next.led            = led_on;
		result_next.event_status   = status_q;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nominal_q <= pil_pkg::NOMINAL_RST;
			tol_q     <= pil_pkg::TOL_RST;
			mult_q    <= pil_pkg::MULT_RST;
			timeout_q <= pil_pkg::TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				pil_pkg::REG_NOMINAL: nominal_q <= cfg_data[NW-1:0];
				pil_pkg::REG_TOL:     tol_q     <= cfg_data[pil_pkg::TOL_W-1:0];
				pil_pkg::REG_MULT:    mult_q    <= cfg_data[pil_pkg::MULT_W-1:0];
				pil_pkg::REG_TIMEOUT: timeout_q <= cfg_data[pil_pkg::TIMEOUT_W-1:0];
				default: ;
			endcase
		end
	end

	// gap store, written at the fill count
	always_ff @(posedge clk) begin
		if (state_q == S_CHECK && store_ok) begin
			store_q[count_q[IDX_W-1:0]] <= fold_q;
		end
	end

	// sequencer with its working registers and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			last_any_q     <= '0;
			last_ref_q     <= '0;
			count_q        <= '0;
			learned_q      <= '0;
			now_q          <= '0;
			gap_q          <= '0;
			fold_q         <= '0;
			status_q       <= pil_pkg::EV_TICK;
			scan_q         <= '0;
			lo_q           <= '0;
			hi_q           <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			// output beat valid: set on a load, cleared once taken
			if (state_q == S_EMIT && (!result_valid_q || !result_stall)) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						now_q    <= item.now;
						status_q <= pil_pkg::EV_TICK;
						state_q  <= S_EMIT;
						if (item.cmd) begin
							last_any_q <= item.now;
							if (item.channel != 2'd0) begin
								status_q <= pil_pkg::EV_OTHER;
							end else if (last_ref_q == '0) begin
								last_ref_q <= item.now;
								status_q   <= pil_pkg::EV_REF;
							end else begin
								gap_q      <= item.now - last_ref_q;
								last_ref_q <= item.now;
								state_q    <= S_FOLD;
							end
						end
					end
				end
				S_FOLD: begin
					fold_q  <= gap_q;
					state_q <= needs_fold ? S_DIV_CNT : S_CHECK;
				end
				S_DIV_CNT: begin
					if (div_done) begin
						if (cnt_over) begin
							fold_q  <= '0;
							state_q <= S_CHECK;
						end else begin
							state_q <= S_DIV_GAP;
						end
					end
				end
				S_DIV_GAP: begin
					if (div_done) begin
						fold_q  <= div_quo[TW-1:0];
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					state_q <= S_EMIT;
					if (win_reject) begin
						status_q <= pil_pkg::EV_REJECT;
					end else if (store_full) begin
						status_q <= pil_pkg::EV_FULL;
					end else begin
						count_q  <= count_q + 1'b1;
						status_q <= pil_pkg::EV_STORED;
						if (32'(count_q) == 32'(GAP_SLOTS - 1)) begin
							scan_q  <= '0;
							lo_q    <= '1;
							hi_q    <= '0;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (scan_rd < lo_q) lo_q <= scan_rd;
					if (scan_rd > hi_q) hi_q <= scan_rd;
					if (scan_q == IDX_W'(GAP_SLOTS - 1)) begin
						state_q <= S_SPREAD;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_SPREAD: begin
					state_q <= S_EMIT;
					if (spread <= TW'(1)) begin
						learned_q <= hi_q;
						status_q  <= pil_pkg::EV_LEARNED;
					end else begin
						last_any_q <= '0;
						last_ref_q <= '0;
						count_q    <= '0;
						learned_q  <= '0;
						status_q   <= pil_pkg::EV_RESTART;
					end
				end
				S_EMIT: begin
					if (!result_valid_q || !result_stall) begin
						result_q <= result_next;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
